// ===== rtl/point_light_radiance_defines.svh =====
// assertion macros for the point light radiance block
// used by point_light_radiance.sv; expects clk and rst in scope
`ifndef POINT_LIGHT_RADIANCE_DEFINES_SVH
`define POINT_LIGHT_RADIANCE_DEFINES_SVH

// same-cycle implication
`define PRL_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PRL_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/prl_pkg.sv =====
// shared types and constants for the point light radiance block
// no dependencies
`timescale 1ns / 1ps

package prl_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int MAG_W     = 33;
  localparam int SQ_W      = 66;
  localparam int DIST_W    = 33;
  localparam int SQ_REM_W  = 35;
  localparam int DIR_W     = 16;
  localparam int COL_W     = 16;
  localparam int Q_BITS    = 16;
  localparam int DIR_SH    = 15;
  localparam int DIR_NUM_W = 49;
  localparam int DIR_DEN_W = 34;
  localparam int SQRT_CELLS = 33;
  localparam int DIV_CELLS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [DIR_W-1:0] DIR_ONE = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_X = 3'd0,
    REG_POS_Y = 3'd1,
    REG_POS_Z = 3'd2,
    REG_RED   = 3'd3,
    REG_GREEN = 3'd4,
    REG_BLUE  = 3'd5
  } cfg_reg_t;

  // item payload while the square root runs
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [SQ_W-1:0]       sumsq;
  } sq_pay_t;

  // item payload while the divisions run
  typedef struct packed {
    logic [2:0]        neg;
    logic [DIST_W-1:0] root;
    logic              at_light;
  } dv_pay_t;

endpackage

// ===== rtl/prl_sqrt_cell.sv =====
// one digit step of the integer square root, registered
// depends on prl_pkg
`timescale 1ns / 1ps

module prl_sqrt_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [prl_pkg::SQ_REM_W-1:0]  rem_in,
  input  logic [prl_pkg::DIST_W-1:0]    root_in,
  input  logic [1:0]                    pair_in,
  output logic [prl_pkg::SQ_REM_W-1:0]  rem_out,
  output logic [prl_pkg::DIST_W-1:0]    root_out
);

  localparam int SW = prl_pkg::SQ_REM_W + 2;

  logic [SW-1:0] rem_sh;
  logic [SW-1:0] trial;
  logic          ge;

  always_comb begin
    rem_sh = {rem_in, pair_in};
    trial  = {2'b00, root_in, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? prl_pkg::SQ_REM_W'(rem_sh - trial) : prl_pkg::SQ_REM_W'(rem_sh);
      root_out <= {root_in[prl_pkg::DIST_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/prl_div_cell.sv =====
// one quotient bit of a restoring division, registered
// depends on prl_pkg
`timescale 1ns / 1ps

module prl_div_cell #(
  parameter int REM_W = 49,
  parameter int DIV_W = 34,
  parameter int SHIFT = 15
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [REM_W-1:0]            rem_in,
  input  logic [DIV_W-1:0]            div_in,
  input  logic [prl_pkg::Q_BITS-1:0]  q_in,
  output logic [REM_W-1:0]            rem_out,
  output logic [prl_pkg::Q_BITS-1:0]  q_out
);

  localparam int CW = (REM_W > DIV_W + SHIFT) ? REM_W : DIV_W + SHIFT;

  logic [CW-1:0]               sh;
  logic [CW-1:0]               ext;
  logic                        fits;
  logic [prl_pkg::Q_BITS-1:0]  q_next;

  always_comb begin
    sh   = CW'(div_in) << SHIFT;
    ext  = CW'(rem_in);
    fits = sh <= ext;
    q_next = q_in;
    q_next[SHIFT] = fits;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? REM_W'(ext - sh) : rem_in;
      q_out   <= q_next;
    end
  end

endmodule

// ===== rtl/point_light_radiance.sv =====
// top level of the point light radiance block
// depends on prl_pkg, prl_sqrt_cell, prl_div_cell, point_light_radiance_defines.svh
`timescale 1ns / 1ps
`include "point_light_radiance_defines.svh"

// lighting from one point light at a surface hit point. each item is a hit
// point; the result is the distance to the light, the unit direction toward
// it and the light colour scaled by the inverse square of the distance,
// saturating at the top of the q8.8 range. a hit exactly at the light sets
// at_light, zeroes the direction and saturates the radiance. the block takes
// one item every cycle; each item passes the registers for difference,
// magnitude, square and sum, a chain of 33 square-root cells
// (one root bit each), a chain of 16 division cells (one quotient bit each,
// three direction lanes and three colour lanes side by side) and the output
// register. the whole chain moves whenever the output register is empty or
// being read, so a stall on the output holds every item in place.
// configuration must be written only while no item is in flight; the block does not enforce it.
module point_light_radiance #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  // config write port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_addr,
  input  logic [31:0]   cfg_data,
  // hit point items
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // hit_x, hit_y, hit_z
  // result items
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // dir_x, dir_y, dir_z, distance, rad_red,
                                        // rad_green, rad_blue, zero pad
  output logic          m_axis_tuser    // at_light
);

  localparam int NUM_W = prl_pkg::COL_W + 2 * COORD_FRAC_BITS;
  localparam int NSQ   = prl_pkg::SQRT_CELLS;
  localparam int NDV   = prl_pkg::DIV_CELLS;

  // configuration registers
  logic signed [31:0] pos [0:2];
  logic [15:0]        col [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0; pos[1] <= '0; pos[2] <= '0;
      col[0] <= '0; col[1] <= '0; col[2] <= '0;
    end else if (cfg_we) begin
      case (prl_pkg::cfg_reg_t'(cfg_addr))
        prl_pkg::REG_POS_X: pos[0] <= cfg_data;
        prl_pkg::REG_POS_Y: pos[1] <= cfg_data;
        prl_pkg::REG_POS_Z: pos[2] <= cfg_data;
        prl_pkg::REG_RED:   col[0] <= cfg_data[15:0];
        prl_pkg::REG_GREEN: col[1] <= cfg_data[15:0];
        prl_pkg::REG_BLUE:  col[2] <= cfg_data[15:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  // whole chain advances together
  logic adv;
  logic out_vld;
  assign adv = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;

  // front: difference, magnitude, square, sum
  logic v_a, v_b, v_c;
  logic vld_sq [0:NSQ];
  logic vld_dv [1:NDV];

  logic signed [prl_pkg::DIFF_W-1:0] d_a [0:2];
  logic [2:0]                        neg_b, neg_c;
  logic [prl_pkg::MAG_W-1:0]         mag_b [0:2];
  logic [prl_pkg::MAG_W-1:0]         mag_c [0:2];
  logic [prl_pkg::SQ_W-1:0]          sq_c  [0:2];

  prl_pkg::sq_pay_t sq_pay [0:NSQ];
  prl_pkg::dv_pay_t dv_head;
  prl_pkg::dv_pay_t dv_pay [1:NDV];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0; v_b <= 1'b0; v_c <= 1'b0; out_vld <= 1'b0;
      for (int i = 0; i <= NSQ; i++) vld_sq[i] <= 1'b0;
      for (int i = 1; i <= NDV; i++) vld_dv[i] <= 1'b0;
    end else if (adv) begin
      v_a <= s_axis_tvalid;
      v_b <= v_a;
      v_c <= v_b;
      vld_sq[0] <= v_c;
      for (int i = 1; i <= NSQ; i++) vld_sq[i] <= vld_sq[i-1];
      vld_dv[1] <= vld_sq[NSQ];
      for (int i = 2; i <= NDV; i++) vld_dv[i] <= vld_dv[i-1];
      out_vld <= vld_dv[NDV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_a[i] <= {pos[i][31], pos[i]} -
                  {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]};
        neg_b[i] <= d_a[i][prl_pkg::DIFF_W-1];
        mag_b[i] <= d_a[i][prl_pkg::DIFF_W-1] ? prl_pkg::MAG_W'(-d_a[i])
                                              : prl_pkg::MAG_W'(d_a[i]);
        mag_c[i] <= mag_b[i];
        sq_c[i]  <= mag_b[i] * mag_b[i];
        sq_pay[0].mag[i] <= mag_c[i];
      end
      neg_c <= neg_b;
      sq_pay[0].neg   <= neg_c;
      sq_pay[0].sumsq <= sq_c[0] + sq_c[1] + sq_c[2];
      for (int i = 1; i <= NSQ; i++) sq_pay[i] <= sq_pay[i-1];
      dv_pay[1] <= dv_head;
      for (int i = 2; i <= NDV; i++) dv_pay[i] <= dv_pay[i-1];
    end
  end

  // square root chain, two radicand bits per cell
  logic [prl_pkg::SQ_REM_W-1:0] sq_rem  [1:NSQ];
  logic [prl_pkg::DIST_W-1:0]   sq_root [1:NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [prl_pkg::SQ_REM_W-1:0] r_in;
    logic [prl_pkg::DIST_W-1:0]   t_in;
    if (j == 0) begin : g_first
      assign r_in = '0;
      assign t_in = '0;
    end else begin : g_rest
      assign r_in = sq_rem[j];
      assign t_in = sq_root[j];
    end
    prl_sqrt_cell u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (r_in),
      .root_in  (t_in),
      .pair_in  (sq_pay[j].sumsq[2*(NSQ-1-j)+1 -: 2]),
      .rem_out  (sq_rem[j+1]),
      .root_out (sq_root[j+1])
    );
  end

  // division heads: direction numerator m*32768 + dist over 2*dist,
  // radiance numerator colour << 2F over sum of squares
  logic [prl_pkg::DIST_W-1:0] dist_h;
  assign dist_h = sq_root[NSQ];

  always_comb begin
    dv_head.neg      = sq_pay[NSQ].neg;
    dv_head.root     = dist_h;
    dv_head.at_light = (sq_pay[NSQ].sumsq == '0);
  end

  logic [prl_pkg::DIR_NUM_W-1:0] dr_rem [1:NDV][0:2];
  logic [prl_pkg::Q_BITS-1:0]    dr_q   [1:NDV][0:2];
  logic [NUM_W-1:0]              rd_rem [1:NDV][0:2];
  logic [prl_pkg::Q_BITS-1:0]    rd_q   [1:NDV][0:2];
  logic [prl_pkg::SQ_W-1:0]      sum_dv [1:NDV-1];

  // divisor for the colour lanes rides beside the chain
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_dv[1] <= sq_pay[NSQ].sumsq;
      for (int i = 2; i < NDV; i++) sum_dv[i] <= sum_dv[i-1];
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_div
    logic [prl_pkg::DIST_W-1:0] dist_j;
    logic [prl_pkg::SQ_W-1:0]   sum_j;
    if (j == 0) begin : g_d0
      assign dist_j = dist_h;
      assign sum_j  = sq_pay[NSQ].sumsq;
    end else begin : g_dn
      assign dist_j = dv_pay[j].root;
      assign sum_j  = sum_dv[j];
    end
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [prl_pkg::DIR_NUM_W-1:0] dn_in;
      logic [prl_pkg::Q_BITS-1:0]    dq_in;
      logic [NUM_W-1:0]              rn_in;
      logic [prl_pkg::Q_BITS-1:0]    rq_in;
      if (j == 0) begin : g_h
        assign dn_in = {1'b0, sq_pay[NSQ].mag[c], {prl_pkg::DIR_SH{1'b0}}} +
                       prl_pkg::DIR_NUM_W'(dist_h);
        assign dq_in = '0;
        assign rn_in = {col[c], {(2*COORD_FRAC_BITS){1'b0}}};
        assign rq_in = '0;
      end else begin : g_t
        assign dn_in = dr_rem[j][c];
        assign dq_in = dr_q[j][c];
        assign rn_in = rd_rem[j][c];
        assign rq_in = rd_q[j][c];
      end
      prl_div_cell #(
        .REM_W (prl_pkg::DIR_NUM_W),
        .DIV_W (prl_pkg::DIR_DEN_W),
        .SHIFT (NDV-1-j)
      ) u_dir (
        .clk     (clk),
        .en      (adv),
        .rem_in  (dn_in),
        .div_in  ({dist_j, 1'b0}),
        .q_in    (dq_in),
        .rem_out (dr_rem[j+1][c]),
        .q_out   (dr_q[j+1][c])
      );
      prl_div_cell #(
        .REM_W (NUM_W),
        .DIV_W (prl_pkg::SQ_W),
        .SHIFT (NDV-1-j)
      ) u_rad (
        .clk     (clk),
        .en      (adv),
        .rem_in  (rn_in),
        .div_in  (sum_j),
        .q_in    (rq_in),
        .rem_out (rd_rem[j+1][c]),
        .q_out   (rd_q[j+1][c])
      );
    end
  end

  // output: clamp and sign the direction, zero it at the light
  logic [prl_pkg::DIR_W-1:0] dir_f [0:2];
  logic [prl_pkg::DIR_W-1:0] qc;

  always_comb begin
    qc = '0;
    for (int i = 0; i < 3; i++) begin
      qc = (dr_q[NDV][i] > prl_pkg::DIR_ONE) ? prl_pkg::DIR_ONE : dr_q[NDV][i];
      if (dv_pay[NDV].at_light) begin
        dir_f[i] = '0;
      end else if (dv_pay[NDV].neg[i]) begin
        dir_f[i] = -qc;
      end else begin
        dir_f[i] = qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {7'b0, rd_q[NDV][2], rd_q[NDV][1], rd_q[NDV][0],
                       dv_pay[NDV].root, dir_f[2], dir_f[1], dir_f[0]};
      m_axis_tuser <= dv_pay[NDV].at_light;
    end
  end

  assign m_axis_tvalid = out_vld;

  // checks
  `PRL_CHECK(a_at_light_out, m_axis_tvalid && m_axis_tuser,
             m_axis_tdata[47:0] == '0 && m_axis_tdata[128:81] == '1,
             "at_light result without zero direction and full radiance")
  `PRL_CHECK(a_dist_nonzero, m_axis_tvalid && !m_axis_tuser,
             m_axis_tdata[80:48] != '0, "zero distance without at_light")
  `PRL_CHECK(a_dir_range, m_axis_tvalid,
             $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
             $signed(m_axis_tdata[15:0]) >= -16'sd16384,
             "direction x out of unit range")
  `PRL_CHECK_NEXT(a_take_in, s_axis_tvalid && s_axis_tready, v_a,
                  "accepted item lost at first stage")

endmodule

// ===== tb/point_light_radiance_test.sv =====
// self-checking bench for point_light_radiance: hit point items in, lighting items out
// depends on prl_pkg and the point_light_radiance rtl
`timescale 1ns / 1ps

module point_light_radiance_test;

  // write to an index past the last register, the block ignores it
  localparam logic [2:0] CFG_ADDR_UNUSED = 3'd6;
  localparam int PIPE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 1900;

  // one expected lighting item
  typedef struct packed {
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [32:0] distance;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        at_light;
  } lighting_t;

  // predicts the lighting for each accepted hit point and checks results in order
  class lighting_scoreboard;
    logic signed [31:0] light_pos [3];
    logic [15:0]        light_col [3];
    lighting_t          pending [$];
    int                 errors;
    int                 checked;
    int                 lit_hits;

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        prl_pkg::REG_POS_X: light_pos[0] = val;
        prl_pkg::REG_POS_Y: light_pos[1] = val;
        prl_pkg::REG_POS_Z: light_pos[2] = val;
        prl_pkg::REG_RED:   light_col[0] = val[15:0];
        prl_pkg::REG_GREEN: light_col[1] = val[15:0];
        prl_pkg::REG_BLUE:  light_col[2] = val[15:0];
        default: ;
      endcase
    endfunction

    // the full lighting computation for one hit point
    function void note_hit(logic [95:0] hit);
      longint        diff [3];
      logic [32:0]   mag [3];
      logic [65:0]   sumsq;
      logic [32:0]   root;
      logic [32:0]   trial;
      logic [63:0]   q;
      logic [65:0]   quot;
      logic [15:0]   dir [3];
      logic [15:0]   rad [3];
      lighting_t     e;
      sumsq = '0;
      for (int i = 0; i < 3; i++) begin
        diff[i] = longint'(light_pos[i]) - longint'($signed(hit[32*i +: 32]));
        mag[i] = (diff[i] < 0) ? 33'(-diff[i]) : 33'(diff[i]);
        sumsq += 66'(mag[i]) * 66'(mag[i]);
      end
      // bit-serial floor square root
      root = '0;
      for (int b = 32; b >= 0; b--) begin
        trial = root | (33'd1 << b);
        if (66'(trial) * 66'(trial) <= sumsq)
          root = trial;
      end
      for (int i = 0; i < 3; i++) begin
        if (root == 0) begin
          dir[i] = '0;
        end else begin
          // round half away from zero, clamp the overshoot from the floored root
          q = (64'(mag[i]) * 64'd32768 + 64'(root)) / (64'd2 * 64'(root));
          if (q > 64'd16384)
            q = 64'd16384;
          dir[i] = (diff[i] < 0) ? 16'(-q) : 16'(q);
        end
        if (sumsq == 0) begin
          rad[i] = 16'hFFFF;
        end else begin
          quot = {18'd0, light_col[i], 32'd0} / sumsq;
          rad[i] = (quot > 66'd65535) ? 16'hFFFF : quot[15:0];
        end
      end
      e.dir_x = dir[0];
      e.dir_y = dir[1];
      e.dir_z = dir[2];
      e.distance = root;
      e.red = rad[0];
      e.green = rad[1];
      e.blue = rad[2];
      e.at_light = (sumsq == 0);
      pending.push_back(e);
    endfunction

    function void check_result(logic [135:0] data, logic user);
      lighting_t e;
      if (pending.size() == 0) begin
        $error("lighting item with none expected: data=%h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.at_light)
        lit_hits++;
      if (data[15:0] !== e.dir_x) begin
        $error("dir_x expected %0d got %0d", $signed(e.dir_x), $signed(data[15:0]));
        errors++;
      end
      if (data[31:16] !== e.dir_y) begin
        $error("dir_y expected %0d got %0d", $signed(e.dir_y), $signed(data[31:16]));
        errors++;
      end
      if (data[47:32] !== e.dir_z) begin
        $error("dir_z expected %0d got %0d", $signed(e.dir_z), $signed(data[47:32]));
        errors++;
      end
      if (data[80:48] !== e.distance) begin
        $error("distance expected %0d got %0d", e.distance, data[80:48]);
        errors++;
      end
      if (data[96:81] !== e.red) begin
        $error("rad_red expected %0d got %0d", e.red, data[96:81]);
        errors++;
      end
      if (data[112:97] !== e.green) begin
        $error("rad_green expected %0d got %0d", e.green, data[112:97]);
        errors++;
      end
      if (data[128:113] !== e.blue) begin
        $error("rad_blue expected %0d got %0d", e.blue, data[128:113]);
        errors++;
      end
      if (user !== e.at_light) begin
        $error("at_light expected %0b got %0b", e.at_light, user);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_addr = '0;
  logic [31:0]   cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;   // hit_x, hit_y, hit_z
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;        // dir_x, dir_y, dir_z, distance, rad_red,
                                      // rad_green, rad_blue, zero pad
  logic          m_axis_tuser;        // at_light

  lighting_scoreboard sb = new();
  int hits_sent;
  int phases_run;
  int burst_left;

  always #2 clk = ~clk;

  point_light_radiance dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // receiver: the stall style is picked anew at random,
  // from always ready through random to long stalls and a repeating pattern
  int stall_mode;
  int stall_count;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    stall_count <= stall_count + 1;
    if (stall_count % 256 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (stall_count % 16) < 11;
    endcase
  end

  // one register write per cycle; the caller drops the write enable
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_light(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [15:0] r, logic [15:0] g, logic [15:0] b);
    write_reg(prl_pkg::REG_POS_X, px);
    write_reg(prl_pkg::REG_POS_Y, py);
    write_reg(prl_pkg::REG_POS_Z, pz);
    write_reg(prl_pkg::REG_RED, {16'd0, r});
    write_reg(prl_pkg::REG_GREEN, {16'd0, g});
    write_reg(prl_pkg::REG_BLUE, {16'd0, b});
    // unused index, must not disturb anything
    write_reg(CFG_ADDR_UNUSED, $urandom);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // one item onto the input; valid stays high inside a burst,
  // a gap of random length follows when the burst runs out
  task automatic send_hit(logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hz, hy, hx};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_hit({hz, hy, hx});
    hits_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // mostly hits near the light so direction and radiance are interesting,
  // some exactly at the light, the rest spread over the whole coordinate range
  function automatic logic [31:0] pick_coord(logic [31:0] centre, int kind);
    case (kind)
      0: return $urandom;
      1: return centre + 32'($signed($urandom_range(0, 4000)) - 2000);
      2: return centre + 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      3: return centre + 32'($signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
      default: return centre;
    endcase
  endfunction

  task automatic random_hits(int count);
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      kind = (kind < 2) ? 0 : (kind < 4) ? 1 : (kind < 6) ? 2 : (kind < 9) ? 3 : 4;
      send_hit(pick_coord(sb.light_pos[0], kind), pick_coord(sb.light_pos[1], kind),
               pick_coord(sb.light_pos[2], kind));
    end
  endtask

  initial begin
    sb.errors = 0;
    sb.checked = 0;
    sb.lit_hits = 0;
    for (int i = 0; i < 3; i++) begin
      sb.light_pos[i] = '0;
      sb.light_col[i] = '0;
    end
    burst_left = 5;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: dark light at the origin
    send_hit(32'd0, 32'd0, 32'd0);
    send_hit(32'h0001_0000, 32'd0, 32'd0);
    random_hits(60);
    drain_results();

    // directed: bright light at the origin, extremes and axis hits
    load_light(32'd0, 32'd0, 32'd0, 16'hFFFF, 16'h0100, 16'h0000);
    send_hit(32'd0, 32'd0, 32'd0);
    send_hit(32'h0001_0000, 32'd0, 32'd0);
    send_hit(32'd0, 32'hFFFF_0000, 32'd0);
    send_hit(32'd0, 32'd0, 32'h0002_0000);
    send_hit(32'd1, 32'd0, 32'd0);
    send_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_hit(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_hit(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_hit(32'd3, 32'd4, 32'd0);
    drain_results();

    // directed: light at opposite extreme corners, largest differences
    load_light(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 16'hFFFF, 16'h8000);
    send_hit(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_hit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_hit(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_hit(32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF);
    send_hit(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    random_hits(300);
    drain_results();

    load_light(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000, 16'hFFFF);
    random_hits(300);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      load_light($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      random_hits((RANDOM_ITEMS - 960) / 4);
      drain_results();
    end

    load_light($urandom_range(0, 32'h3FFFF), 32'h0001_8000, 32'hFFFE_0000,
               16'h0800, 16'h4000, 16'h0010);
    random_hits(300);
    drain_results();

    $display("covered %0d hit points over %0d light settings", hits_sent, phases_run);
    $display("checked %0d lighting items, %0d of them at the light", sb.checked, sb.lit_hits);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
